// ----- sv/nearest_neighbor_scale_address_gen_top_assert.svh -----
// ----------------------------------------------------------------------------
// nearest neighbor scaler assertion macros
// shared property forms for the scaler address generator checkers
// ----------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_TOP_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define NNSAG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define NNSAG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/nnsag_pkg.sv -----
// ----------------------------------------------------------------------------
// nearest neighbor scaler package
// widths, register indexes, control structs and helpers for the scaler
// ----------------------------------------------------------------------------
package nnsag_pkg;

    // dimension registers and walk widths
    localparam int MAX_DIMENSION = 2048;
    localparam int DIM_W         = 12;
    localparam int CNT_W         = 11;
    localparam int ADDR_W        = 22;
    localparam int ERR_W         = 23;
    localparam int PAD_W         = 6;
    localparam int TDATA_IN_W    = 8;
    localparam int TDATA_OUT_W   = 72;
    localparam int TUSER_OUT_W   = 2;
    localparam int CFG_IDX_W     = 2;
    localparam int DIV_STEPS     = DIM_W;
    localparam int DIV_CNT_W     = $clog2(DIV_STEPS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TGT_HEIGHT = 2'd3;

    // register reset values
    localparam logic [DIM_W-1:0] RST_WIDTH  = 12'd720;
    localparam logic [DIM_W-1:0] RST_HEIGHT = 12'd480;

    // controller to datapath commands
    typedef struct packed {
        logic clear_walk;
        logic div_start;
        logic div_sel_y;
        logic latch_x;
        logic latch_y;
        logic mul_load;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_sts;

    // zero reads as one, oversize clamps to the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if ({1'b0, v} > (DIM_W+1)'(MAX_DIMENSION)) begin
            r = DIM_W'(MAX_DIMENSION);
        end
        return r;
    endfunction

endpackage

// ----- sv/nearest_neighbor_scale_address_gen_top.sv -----
// ----------------------------------------------------------------------------
// nearest neighbor scale address generator
// Each input word advances one target pixel in raster order and yields one
// output word with the nearest source column, row and linear address. A word
// goes through accept, row-base multiply, then address add and walk update,
// which waits while the output register holds an untaken word. A word with
// restart set first gets its x and y steps from one shared restoring divider,
// x axis then y axis. The output register lets the next word be taken while
// a result waits. Output tdata bits from the lowest: source_column,
// source_row, source_address, target_column, target_row, zero padding.
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address_gen_top import nnsag_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input stream
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [TDATA_IN_W-1:0]  i_s_tdata,   // [0] restart, rest unused
    // output stream
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,   // source_column, source_row,
                                                // source_address, target_column,
                                                // target_row, zero pad
    output logic [TUSER_OUT_W-1:0] o_m_tuser,   // [0] row_repeats, [1] end_of_row
    output logic                   o_m_tlast,   // end_of_frame
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // dimension registers always take a write
    assign o_cfg_ready = 1'b1;

    nnsag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_restart  (i_s_tdata[0]),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    nnsag_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

// ----- sv/nnsag_div.sv -----
// ----------------------------------------------------------------------------
// nnsag divider
// restoring divider, one quotient bit per cycle, for the step set-up
// ----------------------------------------------------------------------------
module nnsag_div import nnsag_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIM_W-1:0] i_dividend,
    input  logic [DIM_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIM_W-1:0] o_quo,
    output logic [CNT_W-1:0] o_rem
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIM_W-1:0]     r_quo;
    logic [DIM_W-1:0]     r_rem;
    logic [DIM_W-1:0]     r_dvs;

    logic [DIM_W:0]       w_shift;
    logic [DIM_W:0]       w_diff;
    logic                 w_ge;

    // one trial subtract per cycle
    assign w_shift = {r_rem, r_quo[DIM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = w_shift >= {1'b0, r_dvs};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // quotient and partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIM_W-1:0] : w_shift[DIM_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem[CNT_W-1:0];

endmodule

// ----- sv/nnsag_dpath.sv -----
// ----------------------------------------------------------------------------
// nnsag datapath
// dimension registers, raster walk with error stepping, address multiply,
// step divider and output word register
// ----------------------------------------------------------------------------
module nnsag_dpath import nnsag_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DIM_W-1:0]       i_cfg_data,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic                   i_m_tready,
    output logic                   o_m_tvalid,
    output logic [TDATA_OUT_W-1:0] o_m_tdata,
    output logic [TUSER_OUT_W-1:0] o_m_tuser,
    output logic                   o_m_tlast
);

    // dimension registers
    logic [DIM_W-1:0] r_src_w, r_src_h, r_tgt_w, r_tgt_h;
    logic [DIM_W-1:0] w_sw, w_sh, w_tw, w_th;

    // walk state
    logic [CNT_W-1:0]  r_col_cnt, r_row_cnt;
    logic [ADDR_W-1:0] r_src_col, r_src_row;
    logic [ERR_W-1:0]  r_err_h, r_err_v;
    logic [DIM_W-1:0]  r_step_ix, r_step_iy;
    logic [CNT_W-1:0]  r_step_fx, r_step_fy;
    logic              r_rep;
    logic [ADDR_W-1:0] r_prod;

    // output word
    logic                   r_m_valid;
    logic [TDATA_OUT_W-1:0] r_m_tdata;
    logic [TUSER_OUT_W-1:0] r_m_tuser;
    logic                   r_m_tlast;

    // divider
    logic             w_div_done;
    logic [DIM_W-1:0] w_div_quo;
    logic [CNT_W-1:0] w_div_rem;

    logic                    w_eor, w_eof;
    logic [ERR_W:0]          w_sum_h, w_sum_v;
    logic                    w_carry_h, w_carry_v;
    logic [ERR_W:0]          w_sub_h, w_sub_v;
    logic [ADDR_W+DIM_W-1:0] w_prod_full;
    logic [ADDR_W-1:0]       w_addr;

    assign w_sw = eff_dim(r_src_w);
    assign w_sh = eff_dim(r_src_h);
    assign w_tw = eff_dim(r_tgt_w);
    assign w_th = eff_dim(r_tgt_h);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= RST_WIDTH;
            r_src_h <= RST_HEIGHT;
            r_tgt_w <= RST_WIDTH;
            r_tgt_h <= RST_HEIGHT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_w <= i_cfg_data;
                REG_SRC_HEIGHT: r_src_h <= i_cfg_data;
                REG_TGT_WIDTH:  r_tgt_w <= i_cfg_data;
                REG_TGT_HEIGHT: r_tgt_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // shared step divider, x axis then y axis
    nnsag_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (i_cmd.div_sel_y ? w_sh : w_sw),
        .i_divisor  (i_cmd.div_sel_y ? w_th : w_tw),
        .o_done     (w_div_done),
        .o_quo      (w_div_quo),
        .o_rem      (w_div_rem)
    );

    // row and frame ends against the live sizes
    assign w_eor = {1'b0, r_col_cnt} >= (w_tw - DIM_W'(1));
    assign w_eof = w_eor && ({1'b0, r_row_cnt} >= (w_th - DIM_W'(1)));

    // horizontal error step
    assign w_sum_h   = {1'b0, r_err_h} + (ERR_W+1)'(r_step_fx);
    assign w_carry_h = w_sum_h >= (ERR_W+1)'(w_tw);
    assign w_sub_h   = w_sum_h - (ERR_W+1)'(w_tw);

    // vertical error step
    assign w_sum_v   = {1'b0, r_err_v} + (ERR_W+1)'(r_step_fy);
    assign w_carry_v = w_sum_v >= (ERR_W+1)'(w_th);
    assign w_sub_v   = w_sum_v - (ERR_W+1)'(w_th);

    // row base, registered before the add
    assign w_prod_full = r_src_row * w_sw;
    assign w_addr      = r_prod + r_src_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_load) begin
            r_prod <= w_prod_full[ADDR_W-1:0];
        end
    end

    // step registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_ix <= DIM_W'(1);
            r_step_fx <= '0;
            r_step_iy <= DIM_W'(1);
            r_step_fy <= '0;
        end else begin
            if (i_cmd.latch_x) begin
                r_step_ix <= w_div_quo;
                r_step_fx <= w_div_rem;
            end
            if (i_cmd.latch_y) begin
                r_step_iy <= w_div_quo;
                r_step_fy <= w_div_rem;
            end
        end
    end

    // raster walk
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear_walk || (i_cmd.out_load && w_eof)) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
            r_src_col <= '0;
            r_src_row <= '0;
            r_err_h   <= '0;
            r_err_v   <= '0;
            r_rep     <= 1'b0;
        end else if (i_cmd.out_load && w_eor) begin
            r_col_cnt <= '0;
            r_src_col <= '0;
            r_err_h   <= '0;
            r_row_cnt <= r_row_cnt + CNT_W'(1);
            r_src_row <= r_src_row + ADDR_W'(r_step_iy) + ADDR_W'(w_carry_v);
            r_err_v   <= w_carry_v ? w_sub_v[ERR_W-1:0] : w_sum_v[ERR_W-1:0];
            r_rep     <= (r_step_iy == '0) && !w_carry_v;
        end else if (i_cmd.out_load) begin
            r_col_cnt <= r_col_cnt + CNT_W'(1);
            r_src_col <= r_src_col + ADDR_W'(r_step_ix) + ADDR_W'(w_carry_h);
            r_err_h   <= w_carry_h ? w_sub_h[ERR_W-1:0] : w_sum_h[ERR_W-1:0];
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_m_tdata <= {{PAD_W{1'b0}}, r_row_cnt, r_col_cnt, w_addr,
                          r_src_row[CNT_W-1:0], r_src_col[CNT_W-1:0]};
            r_m_tuser <= {w_eor, r_rep};
            r_m_tlast <= w_eof;
        end
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.out_free = !r_m_valid || i_m_tready;

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

endmodule

// ----- sv/nnsag_ctrl.sv -----
// ----------------------------------------------------------------------------
// nnsag controller
// sequences accept, step set-up on restart, address multiply and output
// ----------------------------------------------------------------------------
module nnsag_ctrl import nnsag_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    input  logic i_restart,
    output logic o_s_tready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIVX = 3'd1;
    localparam logic [2:0] ST_DIVY = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0] r_state, n_state;
    logic       w_accept;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_restart) begin
                    o_cmd.clear_walk = 1'b1;
                    o_cmd.div_start  = 1'b1;
                    n_state          = ST_DIVX;
                end else if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_DIVX: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_x   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel_y = 1'b1;
                    n_state         = ST_DIVY;
                end
            end
            ST_DIVY: begin
                if (i_sts.div_done) begin
                    o_cmd.latch_y = 1'b1;
                    n_state       = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_load = 1'b1;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- sv/nnsag_checker.sv -----
// ----------------------------------------------------------------------------
// nnsag port checker
// watches the scaler ports for ordering and flag consistency
// ----------------------------------------------------------------------------
`include "nearest_neighbor_scale_address_gen_top_assert.svh"

module nnsag_checker import nnsag_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [TDATA_OUT_W-1:0] o_m_tdata,
    input logic [TUSER_OUT_W-1:0] o_m_tuser,
    input logic                   o_m_tlast
);

    // a stalled word holds
    `NNSAG_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready,
        o_m_tvalid && $stable(o_m_tdata), "output word changed while stalled")

    // one word in the controller: input closes right after an accept
    `NNSAG_ASSERT_NEXT(a_one_in_flight, i_s_tvalid && o_s_tready, !o_s_tready,
        "second word taken while one is in flight")

    // frame end is always a row end
    `NNSAG_ASSERT_NOW(a_eof_is_eor, o_m_tvalid && o_m_tlast, o_m_tuser[1],
        "frame end without row end")

    // first target row never repeats
    `NNSAG_ASSERT_NOW(a_row0_no_rep, o_m_tvalid && (o_m_tdata[65:55] == '0),
        !o_m_tuser[0], "row repeat flagged on first row")

endmodule

bind nearest_neighbor_scale_address_gen_top nnsag_checker u_checker (.*);

// ----- test/nearest_neighbor_scale_address_gen_top_test.sv -----
// ----------------------------------------------------------------------------
// nearest neighbor scale address generator testbench
// Drives restart/continue words into the scaler and predicts every output
// word: source column, row and address, target position, the row repeat flag
// and the row and frame end markers. A short directed walk covers reset steps,
// clamped sizes, frame wrap, upscaling with repeated rows and a size change
// without restart. Random phases then program new sizes while the block is
// idle and walk frames with random gaps and output stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nearest_neighbor_scale_address_gen_top_test import nnsag_pkg::*; ();

    localparam int GAP_MAX       = 19;
    localparam int RANDOM_PIXELS = 800;
    localparam int DRAIN_CYCLES  = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_MAX    = 10;

    // output tdata layout, lowest field last
    typedef struct packed {
        logic [PAD_W-1:0]  pad;
        logic [CNT_W-1:0]  tgt_row;
        logic [CNT_W-1:0]  tgt_col;
        logic [ADDR_W-1:0] src_addr;
        logic [CNT_W-1:0]  src_row;
        logic [CNT_W-1:0]  src_col;
    } t_pixel_word;

    typedef struct {
        t_pixel_word word;
        bit          repeats;
        bit          row_end;
        bit          frame_end;
    } t_pixel;

    // predicts the walk and holds the pixels still owed by the block
    class scale_walk_board;
        logic [DIM_W-1:0] dims [4];
        int unsigned      col_cnt, row_cnt, src_x, src_y, err_x, err_y;
        int unsigned      int_x, frac_x, int_y, frac_y;
        bit               row_reused;
        t_pixel           expected_pixels [$];
        int unsigned      mismatches;

        function new();
            dims[REG_SRC_WIDTH]  = RST_WIDTH;
            dims[REG_SRC_HEIGHT] = RST_HEIGHT;
            dims[REG_TGT_WIDTH]  = RST_WIDTH;
            dims[REG_TGT_HEIGHT] = RST_HEIGHT;
            int_x      = 1;
            frac_x     = 0;
            int_y      = 1;
            frac_y     = 0;
            mismatches = 0;
            rewind();
        endfunction

        function void rewind();
            col_cnt    = 0;
            row_cnt    = 0;
            src_x      = 0;
            src_y      = 0;
            err_x      = 0;
            err_y      = 0;
            row_reused = 0;
        endfunction

        // zero acts as one, oversize acts as the maximum
        function int unsigned dim_in_use(logic [DIM_W-1:0] v);
            if (v == '0) begin
                return 1;
            end
            if (v > MAX_DIMENSION) begin
                return MAX_DIMENSION;
            end
            return v;
        endfunction

        function void note_config(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] v);
            dims[idx] = v;
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void note_pixel(bit restart);
            int unsigned     sw, sh, tw, th, prev_y;
            longint unsigned lin;
            t_pixel          p;
            sw = dim_in_use(dims[REG_SRC_WIDTH]);
            sh = dim_in_use(dims[REG_SRC_HEIGHT]);
            tw = dim_in_use(dims[REG_TGT_WIDTH]);
            th = dim_in_use(dims[REG_TGT_HEIGHT]);

            // restart latches new steps and begins at target pixel zero
            if (restart) begin
                int_x  = sw / tw;
                frac_x = sw % tw;
                int_y  = sh / th;
                frac_y = sh % th;
                rewind();
            end

            p.row_end   = (col_cnt >= tw - 1);
            p.frame_end = p.row_end && (row_cnt >= th - 1);
            p.repeats   = row_reused;
            lin = longint'(src_y) * sw + src_x;
            p.word.pad      = '0;
            p.word.src_col  = CNT_W'(src_x);
            p.word.src_row  = CNT_W'(src_y);
            p.word.src_addr = ADDR_W'(lin);
            p.word.tgt_col  = CNT_W'(col_cnt);
            p.word.tgt_row  = CNT_W'(row_cnt);
            expected_pixels.push_back(p);

            // advance the walk
            if (p.frame_end) begin
                rewind();
            end else if (p.row_end) begin
                prev_y  = src_y;
                col_cnt = 0;
                src_x   = 0;
                err_x   = 0;
                row_cnt++;
                src_y += int_y;
                err_y += frac_y;
                if (err_y >= th) begin
                    err_y -= th;
                    src_y++;
                end
                row_reused = (src_y == prev_y);
            end else begin
                col_cnt++;
                src_x += int_x;
                err_x += frac_x;
                if (err_x >= tw) begin
                    err_x -= tw;
                    src_x++;
                end
            end
        endfunction

        function void field_check(string name, longint unsigned want, longint unsigned got);
            if (want != got) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t mismatch %s: expected %0d, got %0d", $time, name, want, got);
                end
            end
        endfunction

        function void check_pixel(t_pixel got);
            t_pixel want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX) begin
                    $display("%0t output word with nothing pending", $time);
                end
                return;
            end
            want = expected_pixels.pop_front();
            field_check("source_column", want.word.src_col, got.word.src_col);
            field_check("source_row", want.word.src_row, got.word.src_row);
            field_check("source_address", want.word.src_addr, got.word.src_addr);
            field_check("target_column", want.word.tgt_col, got.word.tgt_col);
            field_check("target_row", want.word.tgt_row, got.word.tgt_row);
            field_check("tdata padding", want.word.pad, got.word.pad);
            field_check("row_repeats", want.repeats, got.repeats);
            field_check("end_of_row", want.row_end, got.row_end);
            field_check("end_of_frame", want.frame_end, got.frame_end);
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic [TDATA_IN_W-1:0]  s_tdata;
    logic                   m_tready;
    logic                   cfg_valid;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [DIM_W-1:0]       cfg_data;
    wire                    s_tready;
    wire                    m_tvalid;
    wire [TDATA_OUT_W-1:0]  m_tdata;
    wire [TUSER_OUT_W-1:0]  m_tuser;
    wire                    m_tlast;
    wire                    cfg_ready;
    bit                     tx_quiet;
    bit                     rx_quiet;
    int                     stall_cycles = 0;
    scale_walk_board        board = new();

    always #2 clk = ~clk;

    nearest_neighbor_scale_address_gen_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    function automatic int draw_gap(bit quiet);
        return quiet ? 0 : $urandom_range(0, GAP_MAX);
    endfunction

    // size choice weighted toward small frames, with the extremes mixed in
    function automatic logic [DIM_W-1:0] pick_dim(bit for_target);
        case ($urandom_range(0, 11))
            0: return '0;
            1: return DIM_W'(1);
            2: return DIM_W'(MAX_DIMENSION);
            3: return '1;
            4: return DIM_W'($urandom_range(MAX_DIMENSION + 1, (1 << DIM_W) - 1));
            default: begin
                if (for_target || $urandom_range(0, 1)) begin
                    return DIM_W'($urandom_range(1, 12));
                end
                return DIM_W'($urandom_range(1, MAX_DIMENSION));
            end
        endcase
    endfunction

    // one pixel word, valid held until taken
    task automatic push_pixel(bit restart);
        int gap;
        gap = draw_gap(tx_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'(restart);
        @(posedge clk);
        while (s_tready !== 1'b1) @(posedge clk);
        board.note_pixel(restart);
    endtask

    task automatic stop_pixels();
        s_tvalid <= 1'b0;
    endtask

    // register write, valid left high for a following write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (cfg_ready !== 1'b1) @(posedge clk);
        board.note_config(idx, value);
    endtask

    task automatic cfg_done();
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (board.pending() > 0) @(posedge clk);
    endtask

    // output side with random stalls
    initial begin
        t_pixel got;
        int     stall;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            stall = draw_gap(rx_quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (m_tvalid !== 1'b1) @(posedge clk);
            got.word      = t_pixel_word'(m_tdata);
            got.repeats   = m_tuser[0];
            got.row_end   = m_tuser[1];
            got.frame_end = m_tlast;
            board.check_pixel(got);
        end
    end

    // watchdog on cycles without any word moving
    always @(posedge clk) begin
        if (rst_n === 1'b1) begin
            if ((s_tvalid && s_tready === 1'b1) || (m_tready && m_tvalid === 1'b1) ||
                (cfg_valid && cfg_ready === 1'b1)) begin
                stall_cycles <= 0;
            end else if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t no progress for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
        end
    end

    // stimulus
    initial begin
        int sent;
        int len;
        bit first_restart;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = REG_SRC_WIDTH;
        cfg_data     = '0;
        tx_quiet     = 1'b0;
        rx_quiet     = 1'b0;
        sent         = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset steps, no restart yet
        repeat (3) push_pixel(1'b0);
        stop_pixels();
        wait_drained();

        // zero and oversize sizes, six pixel frame that wraps
        write_reg(REG_SRC_WIDTH, '0);
        write_reg(REG_SRC_HEIGHT, '1);
        write_reg(REG_TGT_WIDTH, DIM_W'(3));
        write_reg(REG_TGT_HEIGHT, DIM_W'(2));
        cfg_done();
        push_pixel(1'b1);
        repeat (6) push_pixel(1'b0);
        stop_pixels();
        wait_drained();

        // upscale, rows repeat after the first
        write_reg(REG_SRC_WIDTH, DIM_W'(2));
        write_reg(REG_SRC_HEIGHT, DIM_W'(1));
        write_reg(REG_TGT_WIDTH, DIM_W'(4));
        write_reg(REG_TGT_HEIGHT, DIM_W'(3));
        cfg_done();
        push_pixel(1'b1);
        repeat (12) push_pixel(1'b0);
        stop_pixels();
        wait_drained();

        // size change with the old steps kept
        write_reg(REG_TGT_WIDTH, '1);
        cfg_done();
        repeat (3) push_pixel(1'b0);
        stop_pixels();

        // random phases
        while (sent < RANDOM_PIXELS) begin
            wait_drained();
            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1)) write_reg(REG_SRC_WIDTH, pick_dim(1'b0));
            if ($urandom_range(0, 1)) write_reg(REG_SRC_HEIGHT, pick_dim(1'b0));
            if ($urandom_range(0, 1)) write_reg(REG_TGT_WIDTH, pick_dim(1'b1));
            if ($urandom_range(0, 1)) write_reg(REG_TGT_HEIGHT, pick_dim(1'b1));
            cfg_done();
            first_restart = ($urandom_range(0, 7) != 0);
            len = $urandom_range(8, 60);
            for (int k = 0; k < len; k++) begin
                push_pixel(k == 0 ? first_restart : ($urandom_range(0, 31) == 0));
                sent++;
            end
            stop_pixels();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
